// ===== rtl/cfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfa_pkg
// shared constants, codes and helpers of the contiguous fit allocator
// ----------------------------------------------------------------------------
package cfa_pkg;

   // default sizing
   localparam int DEF_NUM_BLOCKS = 16;
   localparam int DEF_SIZE_BITS  = 16;

   // port field widths
   localparam int OPCODE_W      = 1;
   localparam int BLOCK_FIELD_W = 4;
   localparam int SIZE_FIELD_W  = 16;
   localparam int MODE_W        = 2;
   localparam int COUNT_W       = 5;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 5;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_LOAD  = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b1;

   // placement policies (code 3 acts as first fit)
   localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
   localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
   localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_FIT_MODE    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT = 1'b1;

   localparam logic [MODE_W-1:0]  FIT_MODE_RST    = FIT_FIRST;
   localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 5'd16;

   // address width of a table with n entries, at least one bit
   function automatic int idx_width(input int n);
      int w;
      w = (n > 1) ? $clog2(n) : 1;
      return w;
   endfunction

endpackage

// ===== rtl/cfa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfa_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module cfa_ram
   import cfa_pkg::*;
#(
   parameter int WIDTH = DEF_SIZE_BITS,
   parameter int DEPTH = DEF_NUM_BLOCKS
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [idx_width(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]              wr_data,
   input  logic                          rd_en,
   input  logic [idx_width(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/contiguous_fit_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_fit_allocator
// free-size table with first, best and worst fit placement
// ----------------------------------------------------------------------------
//
//  channel   ports                                   handshake
//  -------   -------------------------------------   -------------------------
//  request   req_opcode, req_block_index,            beat taken when start is
//            req_size_value                          high and busy is low
//  response  rsp_granted, rsp_chosen_block,          rsp_valid for one cycle,
//            rsp_remaining_size                      always taken
//  csr       csr_index, csr_wr_data                  written when csr_wr_en
//
//  a load beat writes the table in the accept cycle and never raises busy
//  an allocate beat keeps busy high while it scans the first active entries,
//  active being block_count saturated at NUM_BLOCKS; the response shows in the
//  cycle after busy falls, so a new beat can start with the response; the scan
//  length is set by active and by the single read port of the table ram
//  reset clears control and registers only; table entries are garbage until
//  loaded; there is no response back-pressure
//
module contiguous_fit_allocator
   import cfa_pkg::*;
#(
   parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
   parameter int SIZE_BITS  = DEF_SIZE_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   // request
   input  logic                     start,
   output logic                     busy,
   input  logic [OPCODE_W-1:0]      req_opcode,
   input  logic [BLOCK_FIELD_W-1:0] req_block_index,
   input  logic [SIZE_FIELD_W-1:0]  req_size_value,
   // response
   output logic                     rsp_valid,
   output logic                     rsp_granted,
   output logic [BLOCK_FIELD_W-1:0] rsp_chosen_block,
   output logic [SIZE_FIELD_W-1:0]  rsp_remaining_size,
   // csr
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wr_data
);

   localparam int IDX_W = idx_width(NUM_BLOCKS);
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
   localparam int EXT_W = (SIZE_BITS > SIZE_FIELD_W) ? SIZE_BITS : SIZE_FIELD_W;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   // control registers
   logic                     state_ff, state_in;
   logic [CNT_W-1:0]         active_ff, active_in;
   logic [CNT_W-1:0]         issue_cnt_ff, issue_cnt_in;
   logic                     eval_vld_ff, eval_vld_in;
   logic                     found_ff, found_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [MODE_W-1:0]        fit_mode_ff;
   logic [COUNT_W-1:0]       block_count_ff;

   // payload registers
   logic [SIZE_BITS-1:0]     size_ff, size_in;
   logic [IDX_W-1:0]         eval_idx_ff, eval_idx_in;
   logic [IDX_W-1:0]         pick_ff, pick_in;
   logic [SIZE_BITS-1:0]     best_ff, best_in;
   logic                     rsp_granted_ff, rsp_granted_in;
   logic [BLOCK_FIELD_W-1:0] rsp_chosen_ff, rsp_chosen_in;
   logic [SIZE_FIELD_W-1:0]  rsp_remaining_ff, rsp_remaining_in;

   // datapath
   logic                     accept;
   logic                     load_hit;
   logic [EXT_W-1:0]         req_size_ext;
   logic [SIZE_BITS-1:0]     req_size;
   logic [CNT_W-1:0]         active_sat;
   logic                     issue;
   logic                     scan_end;
   logic [IDX_W-1:0]         rd_addr;
   logic [SIZE_BITS-1:0]     rd_data;
   logic                     fits;
   logic                     better;
   logic                     take;
   logic                     nxt_found;
   logic [IDX_W-1:0]         nxt_pick;
   logic [SIZE_BITS-1:0]     nxt_best;
   logic [SIZE_BITS-1:0]     charged;
   logic [EXT_W-1:0]         charged_ext;
   logic                     ram_we;
   logic [IDX_W-1:0]         ram_waddr;
   logic [SIZE_BITS-1:0]     ram_wdata;

   assign busy   = (state_ff == ST_SCAN);
   assign accept = start && !busy;

   // request size masked to the table width
   assign req_size_ext = EXT_W'(req_size_value);
   assign req_size     = req_size_ext[SIZE_BITS-1:0];

   // loads beyond the table are dropped
   assign load_hit = accept && (req_opcode == OP_LOAD) &&
                     (32'(req_block_index) < NUM_BLOCKS);

   // entries taking part, block_count clipped to the table size
   always_comb begin
      if (32'(block_count_ff) > NUM_BLOCKS) begin
         active_sat = CNT_W'(NUM_BLOCKS);
      end else begin
         active_sat = CNT_W'(block_count_ff);
      end
   end

   // one read issued per scan cycle until all active entries are read, data evaluated the cycle after
   assign issue   = (state_ff == ST_SCAN) && (issue_cnt_ff != active_ff);
   assign rd_addr = issue_cnt_ff[IDX_W-1:0];

   // last read data is folded in the same cycle that writes back
   assign scan_end = (state_ff == ST_SCAN) && (issue_cnt_ff == active_ff) &&
                     (eval_vld_ff || (active_ff == '0));

   // candidate selection, ties keep the lower index
   assign fits = (rd_data >= size_ff);

   always_comb begin
      case (fit_mode_ff)
         FIT_BEST:  better = (rd_data < best_ff);
         FIT_WORST: better = (rd_data > best_ff);
         default:   better = 1'b0;
      endcase
   end

   assign take      = eval_vld_ff && fits && (!found_ff || better);
   assign nxt_found = found_ff || (eval_vld_ff && fits);
   assign nxt_pick  = take ? eval_idx_ff : pick_ff;
   assign nxt_best  = take ? rd_data : best_ff;

   assign charged     = nxt_best - size_ff;
   assign charged_ext = EXT_W'(charged);

   // table write port shared by loads (idle) and write-back (scan end)
   assign ram_we    = load_hit || (scan_end && nxt_found);
   assign ram_waddr = scan_end ? nxt_pick : IDX_W'(req_block_index);
   assign ram_wdata = scan_end ? charged : req_size;

   cfa_ram #(
      .WIDTH (SIZE_BITS),
      .DEPTH (NUM_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next-state logic
   always_comb begin
      state_in         = state_ff;
      active_in        = active_ff;
      issue_cnt_in     = issue_cnt_ff;
      found_in         = found_ff;
      size_in          = size_ff;
      pick_in          = pick_ff;
      best_in          = best_ff;
      eval_vld_in      = issue;
      eval_idx_in      = rd_addr;
      rsp_valid_in     = scan_end;
      rsp_granted_in   = nxt_found;
      rsp_chosen_in    = nxt_found ? BLOCK_FIELD_W'(nxt_pick) : '0;
      rsp_remaining_in = nxt_found ? charged_ext[SIZE_FIELD_W-1:0] : '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_opcode == OP_ALLOC)) begin
               state_in     = ST_SCAN;
               size_in      = req_size;
               active_in    = active_sat;
               issue_cnt_in = '0;
               found_in     = 1'b0;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               issue_cnt_in = issue_cnt_ff + CNT_W'(1);
            end
            found_in = nxt_found;
            pick_in  = nxt_pick;
            best_in  = nxt_best;
            if (scan_end) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         issue_cnt_ff <= '0;
         eval_vld_ff  <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         issue_cnt_ff <= issue_cnt_in;
         eval_vld_ff  <= eval_vld_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff          <= size_in;
      eval_idx_ff      <= eval_idx_in;
      pick_ff          <= pick_in;
      best_ff          <= best_in;
      rsp_granted_ff   <= rsp_granted_in;
      rsp_chosen_ff    <= rsp_chosen_in;
      rsp_remaining_ff <= rsp_remaining_in;
   end

   // csr writes, to be made only while idle; the block itself does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff    <= FIT_MODE_RST;
         block_count_ff <= BLOCK_COUNT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FIT_MODE:    fit_mode_ff    <= csr_wr_data[MODE_W-1:0];
            CSR_BLOCK_COUNT: block_count_ff <= csr_wr_data[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted        = rsp_granted_ff;
   assign rsp_chosen_block   = rsp_chosen_ff;
   assign rsp_remaining_size = rsp_remaining_ff;

endmodule

// ===== rtl/cfa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfa_checker
// port-level checks of the contiguous fit allocator
// ----------------------------------------------------------------------------
module cfa_checker
   import cfa_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  logic [OPCODE_W-1:0]      req_opcode,
   input  logic                     rsp_valid,
   input  logic                     rsp_granted,
   input  logic [BLOCK_FIELD_W-1:0] rsp_chosen_block,
   input  logic [SIZE_FIELD_W-1:0]  rsp_remaining_size
);

   // allocation beat holds the request side off
   a_alloc_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_opcode == OP_ALLOC) |=> busy)
      else $error("allocation did not raise busy");

   // load beat leaves busy low and is silent
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_opcode == OP_LOAD) |=> !busy && !rsp_valid)
      else $error("load raised busy or a response");

   // response only closes a busy period
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && $past(busy))
      else $error("response outside an allocation");

   // refused request reports zeros
   a_refuse_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_granted |-> (rsp_chosen_block == '0) &&
                                    (rsp_remaining_size == '0))
      else $error("refused response carries data");

endmodule

bind contiguous_fit_allocator cfa_checker u_cfa_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_opcode         (req_opcode),
   .rsp_valid          (rsp_valid),
   .rsp_granted        (rsp_granted),
   .rsp_chosen_block   (rsp_chosen_block),
   .rsp_remaining_size (rsp_remaining_size)
);
